/* rtl/ldp_pkg.sv */
// ----------------------------------------------------------------------------
// ldp_pkg
// Shared types, register codes and fixed-point helpers for the lens
// distortion projection pipeline.
// ----------------------------------------------------------------------------
package ldp_pkg;

   typedef enum logic [3:0] {
      CSR_FOCAL_X         = 4'd0,
      CSR_FOCAL_Y         = 4'd1,
      CSR_SKEW            = 4'd2,
      CSR_PRINCIPAL_POINT = 4'd3,
      CSR_RADIAL_K1       = 4'd4,
      CSR_RADIAL_K2       = 4'd5,
      CSR_RADIAL_K3       = 4'd6,
      CSR_TANGENTIAL      = 4'd7
   } csr_idx_type;

   localparam int unsigned CsrIdxWidth = 4;

   localparam logic [31:0]        FocalReset = 32'h0001_0000;
   localparam logic signed [31:0] OneQ24     = 32'sh0100_0000;

   localparam logic [5:0] ShQ32 = 6'd32;
   localparam logic [5:0] ShQ28 = 6'd28;
   localparam logic [5:0] ShQ24 = 6'd24;
   localparam logic [5:0] ShQ23 = 6'd23;

   typedef struct packed {
      logic [31:0]        fx;
      logic [31:0]        fy;
      logic signed [31:0] sk;
      logic signed [31:0] u0;
      logic signed [31:0] v0;
      logic signed [31:0] k1;
      logic signed [31:0] k2;
      logic signed [31:0] k3;
      logic signed [31:0] p1;
      logic signed [31:0] p2;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] g;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic               ovf;
   } dist_type;

   typedef struct packed {
      logic signed [31:0] val;
      logic               ovf;
   } sat_type;

   function automatic logic signed [66:0] sx67(input logic signed [31:0] a);
      return {{35{a[31]}}, a};
   endfunction

   function automatic logic signed [32:0] sx33(input logic signed [31:0] a);
      return {a[31], a};
   endfunction

   function automatic logic signed [32:0] ux33(input logic [31:0] a);
      return {1'b0, a};
   endfunction

   function automatic logic signed [65:0] mul33(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
      logic signed [65:0] ae;
      logic signed [65:0] be;
      ae = {{33{a[32]}}, a};
      be = {{33{b[32]}}, b};
      return ae * be;
   endfunction

   // clamp to signed 32 bits
   function automatic sat_type sat32(input logic signed [66:0] v);
      sat_type r;
      if (v[66:31] == {36{v[66]}}) begin
         r.val = v[31:0];
         r.ovf = 1'b0;
      end else begin
         r.val = v[66] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         r.ovf = 1'b1;
      end
      return r;
   endfunction

   // round to nearest, ties up, then clamp
   function automatic sat_type rnd_sat(input logic signed [65:0] p, input logic [5:0] sh);
      logic signed [66:0] t;
      logic signed [66:0] half;
      half = 67'sd1 <<< (sh - 6'd1);
      t    = {p[65], p} + half;
      t    = t >>> sh;
      return sat32(t);
   endfunction

endpackage

/* rtl/ldp_csr.sv */
// ----------------------------------------------------------------------------
// ldp_csr
// Configuration registers: focal lengths, skew, principal point and
// distortion coefficients.
// ----------------------------------------------------------------------------
module ldp_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [ldp_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [63:0]                    csr_wdata,
   output ldp_pkg::cfg_type               cfg
);
   import ldp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FOCAL_X:         cfg_in.fx = csr_wdata[31:0];
            CSR_FOCAL_Y:         cfg_in.fy = csr_wdata[31:0];
            CSR_SKEW:            cfg_in.sk = csr_wdata[31:0];
            CSR_PRINCIPAL_POINT: begin
               cfg_in.u0 = csr_wdata[63:32];
               cfg_in.v0 = csr_wdata[31:0];
            end
            CSR_RADIAL_K1:       cfg_in.k1 = csr_wdata[31:0];
            CSR_RADIAL_K2:       cfg_in.k2 = csr_wdata[31:0];
            CSR_RADIAL_K3:       cfg_in.k3 = csr_wdata[31:0];
            CSR_TANGENTIAL:      begin
               cfg_in.p1 = csr_wdata[63:32];
               cfg_in.p2 = csr_wdata[31:0];
            end
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{fx: FocalReset, fy: FocalReset, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/ldp_radial.sv */
// ----------------------------------------------------------------------------
// ldp_radial
// Eight-stage pipeline from the normalized point to the radial gain and the
// tangential offsets.
// ----------------------------------------------------------------------------
module ldp_radial (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [31:0] in_x,
   input  logic signed [31:0] in_y,
   input  ldp_pkg::cfg_type   cfg,
   output ldp_pkg::dist_type  mid
);
   import ldp_pkg::*;

   localparam int unsigned Depth = 8;

   logic [Depth-1:0] valid_ff;
   logic [Depth-1:0] valid_in;
   logic signed [31:0] x_ff [Depth];
   logic signed [31:0] y_ff [Depth];

   // stage 1
   logic signed [65:0] mxx1_ff, myy1_ff, mxy1_ff;
   // stage 2
   sat_type xx2, yy2, xy2, rr2;
   logic signed [31:0] xx2_ff, yy2_ff, xy2_ff, rr2_ff;
   logic ovf2_ff;
   // stage 3
   sat_type ax3, ay3;
   logic signed [65:0] mr4_3_ff, mk1_3_ff, mp1xy3_ff, mp2xy3_ff;
   logic signed [31:0] ax3_ff, ay3_ff, rr3_ff;
   logic ovf3_ff;
   // stage 4
   sat_type r4_4, t1_4, txy1_4, txy2_4;
   logic signed [31:0] r4_4_ff, t1_4_ff, txy1_4_ff, txy2_4_ff, rr4_ff, ax4_ff, ay4_ff;
   logic ovf4_ff;
   // stage 5
   logic signed [65:0] mr6_5_ff, mk2_5_ff, mp2ax5_ff, mp1ay5_ff;
   logic signed [31:0] t1_5_ff, txy1_5_ff, txy2_5_ff;
   logic ovf5_ff;
   // stage 6
   sat_type r6_6, t2_6, tax6, tay6, dx6, dy6;
   logic signed [31:0] r6_6_ff, t1_6_ff, t2_6_ff, dx6_ff, dy6_ff;
   logic ovf6_ff;
   // stage 7
   logic signed [65:0] mk3_7_ff;
   logic signed [31:0] t1_7_ff, t2_7_ff, dx7_ff, dy7_ff;
   logic ovf7_ff;
   // stage 8
   sat_type t3_8, g8;
   logic signed [31:0] g8_ff, dx8_ff, dy8_ff;
   logic ovf8_ff;

   assign valid_in = {valid_ff[Depth-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= in_x;
      y_ff[0] <= in_y;
      for (int i = 1; i < Depth; i++) begin
         x_ff[i] <= x_ff[i-1];
         y_ff[i] <= y_ff[i-1];
      end
   end

   always_comb begin
      xx2  = rnd_sat(mxx1_ff, ShQ32);
      yy2  = rnd_sat(myy1_ff, ShQ32);
      xy2  = rnd_sat(mxy1_ff, ShQ32);
      rr2  = sat32(sx67(xx2.val) + sx67(yy2.val));
      ax3  = sat32(sx67(rr2_ff) + (sx67(xx2_ff) <<< 1));
      ay3  = sat32(sx67(rr2_ff) + (sx67(yy2_ff) <<< 1));
      r4_4   = rnd_sat(mr4_3_ff, ShQ24);
      t1_4   = rnd_sat(mk1_3_ff, ShQ24);
      txy1_4 = rnd_sat(mp1xy3_ff, ShQ23);
      txy2_4 = rnd_sat(mp2xy3_ff, ShQ23);
      r6_6 = rnd_sat(mr6_5_ff, ShQ24);
      t2_6 = rnd_sat(mk2_5_ff, ShQ24);
      tax6 = rnd_sat(mp2ax5_ff, ShQ24);
      tay6 = rnd_sat(mp1ay5_ff, ShQ24);
      dx6  = sat32(sx67(txy1_5_ff) + sx67(tax6.val));
      dy6  = sat32(sx67(txy2_5_ff) + sx67(tay6.val));
      t3_8 = rnd_sat(mk3_7_ff, ShQ24);
      g8   = sat32(sx67(OneQ24) + sx67(t1_7_ff) + sx67(t2_7_ff) + sx67(t3_8.val));
   end

   always_ff @(posedge clock) begin
      // stage 1: squares and cross product
      mxx1_ff <= mul33(sx33(in_x), sx33(in_x));
      myy1_ff <= mul33(sx33(in_y), sx33(in_y));
      mxy1_ff <= mul33(sx33(in_x), sx33(in_y));
      // stage 2: radius squared
      xx2_ff  <= xx2.val;
      yy2_ff  <= yy2.val;
      xy2_ff  <= xy2.val;
      rr2_ff  <= rr2.val;
      ovf2_ff <= xx2.ovf | yy2.ovf | xy2.ovf | rr2.ovf;
      // stage 3
      mr4_3_ff  <= mul33(sx33(rr2_ff), sx33(rr2_ff));
      mk1_3_ff  <= mul33(sx33(cfg.k1), sx33(rr2_ff));
      mp1xy3_ff <= mul33(sx33(cfg.p1), sx33(xy2_ff));
      mp2xy3_ff <= mul33(sx33(cfg.p2), sx33(xy2_ff));
      ax3_ff    <= ax3.val;
      ay3_ff    <= ay3.val;
      rr3_ff    <= rr2_ff;
      ovf3_ff   <= ovf2_ff | ax3.ovf | ay3.ovf;
      // stage 4
      r4_4_ff   <= r4_4.val;
      t1_4_ff   <= t1_4.val;
      txy1_4_ff <= txy1_4.val;
      txy2_4_ff <= txy2_4.val;
      rr4_ff    <= rr3_ff;
      ax4_ff    <= ax3_ff;
      ay4_ff    <= ay3_ff;
      ovf4_ff   <= ovf3_ff | r4_4.ovf | t1_4.ovf | txy1_4.ovf | txy2_4.ovf;
      // stage 5
      mr6_5_ff  <= mul33(sx33(r4_4_ff), sx33(rr4_ff));
      mk2_5_ff  <= mul33(sx33(cfg.k2), sx33(r4_4_ff));
      mp2ax5_ff <= mul33(sx33(cfg.p2), sx33(ax4_ff));
      mp1ay5_ff <= mul33(sx33(cfg.p1), sx33(ay4_ff));
      t1_5_ff   <= t1_4_ff;
      txy1_5_ff <= txy1_4_ff;
      txy2_5_ff <= txy2_4_ff;
      ovf5_ff   <= ovf4_ff;
      // stage 6: tangential offsets
      r6_6_ff <= r6_6.val;
      t1_6_ff <= t1_5_ff;
      t2_6_ff <= t2_6.val;
      dx6_ff  <= dx6.val;
      dy6_ff  <= dy6.val;
      ovf6_ff <= ovf5_ff | r6_6.ovf | t2_6.ovf | tax6.ovf | tay6.ovf | dx6.ovf | dy6.ovf;
      // stage 7
      mk3_7_ff <= mul33(sx33(cfg.k3), sx33(r6_6_ff));
      t1_7_ff  <= t1_6_ff;
      t2_7_ff  <= t2_6_ff;
      dx7_ff   <= dx6_ff;
      dy7_ff   <= dy6_ff;
      ovf7_ff  <= ovf6_ff;
      // stage 8: radial gain
      g8_ff   <= g8.val;
      dx8_ff  <= dx7_ff;
      dy8_ff  <= dy7_ff;
      ovf8_ff <= ovf7_ff | t3_8.ovf | g8.ovf;
   end

   always_comb begin
      mid.valid = valid_ff[Depth-1];
      mid.x     = x_ff[Depth-1];
      mid.y     = y_ff[Depth-1];
      mid.g     = g8_ff;
      mid.dx    = dx8_ff;
      mid.dy    = dy8_ff;
      mid.ovf   = ovf8_ff;
   end

endmodule

/* rtl/ldp_proj.sv */
// ----------------------------------------------------------------------------
// ldp_proj
// Four-stage pipeline applying the radial gain and the camera matrix,
// with saturated output registers.
// ----------------------------------------------------------------------------
module ldp_proj (
   input  logic               clock,
   input  logic               reset,
   input  ldp_pkg::dist_type  mid,
   input  ldp_pkg::cfg_type   cfg,
   output logic               out_valid,
   output logic signed [31:0] out_u,
   output logic signed [31:0] out_v,
   output logic               out_ovf
);
   import ldp_pkg::*;

   logic [3:0] valid_ff;
   logic [3:0] valid_in;

   // stage 9
   logic signed [65:0] mgx9_ff, mgy9_ff;
   logic signed [31:0] dx9_ff, dy9_ff;
   logic ovf9_ff;
   // stage 10
   sat_type gx10, gy10, pnx10, pny10;
   logic signed [31:0] pnx10_ff, pny10_ff;
   logic ovf10_ff;
   // stage 11
   logic signed [65:0] mfx11_ff, msk11_ff, mfy11_ff;
   logic ovf11_ff;
   // stage 12
   sat_type tfx12, tsk12, tfy12, u12, v12;
   logic signed [31:0] u12_ff, v12_ff;
   logic ovf12_ff;

   assign valid_in = {valid_ff[2:0], mid.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      gx10  = rnd_sat(mgx9_ff, ShQ28);
      gy10  = rnd_sat(mgy9_ff, ShQ28);
      pnx10 = sat32(sx67(gx10.val) + sx67(dx9_ff));
      pny10 = sat32(sx67(gy10.val) + sx67(dy9_ff));
      tfx12 = rnd_sat(mfx11_ff, ShQ24);
      tsk12 = rnd_sat(msk11_ff, ShQ24);
      tfy12 = rnd_sat(mfy11_ff, ShQ24);
      u12   = sat32(sx67(tfx12.val) + sx67(tsk12.val) + sx67(cfg.u0));
      v12   = sat32(sx67(tfy12.val) + sx67(cfg.v0));
   end

   always_ff @(posedge clock) begin
      mgx9_ff  <= mul33(sx33(mid.g), sx33(mid.x));
      mgy9_ff  <= mul33(sx33(mid.g), sx33(mid.y));
      dx9_ff   <= mid.dx;
      dy9_ff   <= mid.dy;
      ovf9_ff  <= mid.ovf;
      // distorted point
      pnx10_ff <= pnx10.val;
      pny10_ff <= pny10.val;
      ovf10_ff <= ovf9_ff | gx10.ovf | gy10.ovf | pnx10.ovf | pny10.ovf;
      // camera matrix products
      mfx11_ff <= mul33(ux33(cfg.fx), sx33(pnx10_ff));
      msk11_ff <= mul33(sx33(cfg.sk), sx33(pny10_ff));
      mfy11_ff <= mul33(ux33(cfg.fy), sx33(pny10_ff));
      ovf11_ff <= ovf10_ff;
      // pixel position
      u12_ff   <= u12.val;
      v12_ff   <= v12.val;
      ovf12_ff <= ovf11_ff | tfx12.ovf | tsk12.ovf | tfy12.ovf | u12.ovf | v12.ovf;
   end

   assign out_valid = valid_ff[3];
   assign out_u     = u12_ff;
   assign out_v     = v12_ff;
   assign out_ovf   = ovf12_ff;

endmodule

/* rtl/lens_distortion_project_unit.sv */
// path: an accepted start passes through the radial and then the projection pipeline to the rsp_valid strobe
// throughput: one point per cycle, busy stays low; the pipeline depth is
//   set by the chain of dependent products r2, r4, r6, gain and pixel
// results leave as one-cycle strobes; the receiver cannot stall
// reset: synchronous, clears the pipeline valid bits and loads focal
//   lengths of 1.0 with all other registers zero
// ----------------------------------------------------------------------------
// lens_distortion_project_unit
// Brown-Conrady radial-tangential projection of a normalized point to a
// pixel position in fixed point.
// ----------------------------------------------------------------------------
module lens_distortion_project_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [31:0]             req_norm_x,
   input  logic signed [31:0]             req_norm_y,
   output logic                           rsp_valid,
   output logic signed [31:0]             rsp_pixel_u,
   output logic signed [31:0]             rsp_pixel_v,
   output logic                           rsp_overflow,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ldp_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [63:0]                    csr_wdata
);
   import ldp_pkg::*;

   cfg_type  cfg;
   dist_type mid;
   logic     accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   ldp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ldp_radial u_radial (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_x     (req_norm_x),
      .in_y     (req_norm_y),
      .cfg      (cfg),
      .mid      (mid)
   );

   ldp_proj u_proj (
      .clock     (clock),
      .reset     (reset),
      .mid       (mid),
      .cfg       (cfg),
      .out_valid (rsp_valid),
      .out_u     (rsp_pixel_u),
      .out_v     (rsp_pixel_v),
      .out_ovf   (rsp_overflow)
   );

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the lens distortion projection unit. A directed
// table of points runs under the reset setting with known pixels, then
// under an all-extreme setting. Random settings and random points follow,
// with bursts of idle on the command side. Every pixel is checked field by
// field against its golden table entry or a fixed-point model of the projection kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
   import ldp_pkg::*;

   localparam int          StallLimit     = 5000;
   localparam int          SettleCycles   = 16;
   localparam int          RandomPhases   = 7;
   localparam int          PointsPerPhase = 200;
   localparam int unsigned CsrSlots       = 1 << CsrIdxWidth;
   localparam int unsigned ThreeHalvesQ28 = 32'h1800_0000;
   localparam logic [31:0] WordMin        = 32'h8000_0000;
   localparam logic [31:0] WordMax        = 32'h7FFF_FFFF;

   typedef struct packed {
      logic signed [31:0] u;
      logic signed [31:0] v;
      logic               ovf;
   } pixel_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic               known;
      pixel_type          gold;
   } probe_type;

   logic                    clock        = 1'b0;
   logic                    reset        = 1'b1;
   logic                    start        = 1'b0;
   logic signed [31:0]      req_norm_x   = '0;
   logic signed [31:0]      req_norm_y   = '0;
   logic                    csr_valid    = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index    = '0;
   logic [63:0]             csr_wdata    = '0;
   logic                    busy;
   logic                    rsp_valid;
   logic signed [31:0]      rsp_pixel_u;
   logic signed [31:0]      rsp_pixel_v;
   logic                    rsp_overflow;
   logic                    csr_ready;

   logic                    gold_armed   = 1'b0;
   pixel_type               gold_pixel   = '0;

   cfg_type                 lens_cfg;
   pixel_type               pending_pixels[$];
   int                      mismatch_count = 0;
   int                      quiet_cycles   = 0;
   bit                      sat_seen;
   probe_type               probe_table [12];

   lens_distortion_project_unit DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_norm_x   (req_norm_x),
      .req_norm_y   (req_norm_y),
      .rsp_valid    (rsp_valid),
      .rsp_pixel_u  (rsp_pixel_u),
      .rsp_pixel_v  (rsp_pixel_v),
      .rsp_overflow (rsp_overflow),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #1 clock = ~clock;

   // fixed-point projection

   function automatic longint clamp_word(longint val);
      if (val > 64'sd2147483647) begin
         sat_seen = 1'b1;
         return 64'sd2147483647;
      end
      if (val < -64'sd2147483648) begin
         sat_seen = 1'b1;
         return -64'sd2147483648;
      end
      return val;
   endfunction

   // round to nearest with ties up, then clamp
   function automatic longint scaled_product(longint a, longint b, int sh);
      longint prod;
      prod = a * b + (longint'(1) <<< (sh - 1));
      return clamp_word(prod >>> sh);
   endfunction

   function automatic pixel_type project_point(cfg_type c, logic signed [31:0] nx,
                                               logic signed [31:0] ny);
      longint x, y, fx, fy, sk, u0, v0, k1, k2, k3, p1, p2;
      longint xx, yy, xy, rr, r4, r6, gain, ax, ay, dx, dy, pnx, pny, pu, pv;
      pixel_type r;
      sat_seen = 1'b0;
      x  = nx;
      y  = ny;
      fx = {32'd0, c.fx};
      fy = {32'd0, c.fy};
      sk = $signed(c.sk);
      u0 = $signed(c.u0);
      v0 = $signed(c.v0);
      k1 = $signed(c.k1);
      k2 = $signed(c.k2);
      k3 = $signed(c.k3);
      p1 = $signed(c.p1);
      p2 = $signed(c.p2);

      xx   = scaled_product(x, x, 32);
      yy   = scaled_product(y, y, 32);
      xy   = scaled_product(x, y, 32);
      rr   = clamp_word(xx + yy);
      r4   = scaled_product(rr, rr, 24);
      r6   = scaled_product(r4, rr, 24);
      gain = clamp_word(longint'(OneQ24) + scaled_product(k1, rr, 24)
                        + scaled_product(k2, r4, 24) + scaled_product(k3, r6, 24));

      ax = clamp_word(rr + 2 * xx);
      ay = clamp_word(rr + 2 * yy);
      dx = clamp_word(scaled_product(p1, xy, 23) + scaled_product(p2, ax, 24));
      dy = clamp_word(scaled_product(p2, xy, 23) + scaled_product(p1, ay, 24));

      pnx = clamp_word(scaled_product(gain, x, 28) + dx);
      pny = clamp_word(scaled_product(gain, y, 28) + dy);

      pu = clamp_word(scaled_product(fx, pnx, 24) + scaled_product(sk, pny, 24) + u0);
      pv = clamp_word(scaled_product(fy, pny, 24) + v0);

      r.u   = pu[31:0];
      r.v   = pv[31:0];
      r.ovf = sat_seen;
      return r;
   endfunction

   function automatic void apply_csr(logic [CsrIdxWidth-1:0] idx, logic [63:0] data);
      case (idx)
         CSR_FOCAL_X:         lens_cfg.fx = data[31:0];
         CSR_FOCAL_Y:         lens_cfg.fy = data[31:0];
         CSR_SKEW:            lens_cfg.sk = data[31:0];
         CSR_PRINCIPAL_POINT: begin
            lens_cfg.u0 = data[63:32];
            lens_cfg.v0 = data[31:0];
         end
         CSR_RADIAL_K1:       lens_cfg.k1 = data[31:0];
         CSR_RADIAL_K2:       lens_cfg.k2 = data[31:0];
         CSR_RADIAL_K3:       lens_cfg.k3 = data[31:0];
         CSR_TANGENTIAL:      begin
            lens_cfg.p1 = data[63:32];
            lens_cfg.p2 = data[31:0];
         end
         default: ;
      endcase
   endfunction

   task automatic flag_mismatch(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // transaction monitor, scoreboard and watchdog

   always @(posedge clock) begin
      if (reset) begin
         lens_cfg     = '0;
         lens_cfg.fx  = FocalReset;
         lens_cfg.fy  = FocalReset;
         quiet_cycles = 0;
      end else begin
         if (rsp_valid) begin
            if (pending_pixels.size() == 0) begin
               flag_mismatch($sformatf("unexpected pixel u=%0d v=%0d", rsp_pixel_u,
                                       rsp_pixel_v));
            end else begin
               pixel_type want;
               want = pending_pixels.pop_front();
               if (rsp_pixel_u !== want.u)
                  flag_mismatch($sformatf("pixel_u %0d, expected %0d", rsp_pixel_u, want.u));
               if (rsp_pixel_v !== want.v)
                  flag_mismatch($sformatf("pixel_v %0d, expected %0d", rsp_pixel_v, want.v));
               if (rsp_overflow !== want.ovf)
                  flag_mismatch($sformatf("overflow %0b, expected %0b", rsp_overflow,
                                          want.ovf));
            end
         end
         if (start && !busy)
            pending_pixels.push_back(gold_armed ? gold_pixel
                                                : project_point(lens_cfg, req_norm_x,
                                                                req_norm_y));
         if (csr_valid && csr_ready)
            apply_csr(csr_index, csr_wdata);

         if (rsp_valid || (start && !busy) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= StallLimit) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // stimulus

   function automatic int spread(int unsigned half);
      return int'($urandom_range(0, 2 * half)) - int'(half);
   endfunction

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(0, 4))
         0:       return WordMin;
         1:       return WordMax;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return spread(ThreeHalvesQ28);
         6, 7:             return $urandom;
         8:                return pick_extreme();
         default:          return spread(4096);
      endcase
   endfunction

   function automatic cfg_type rand_setting();
      cfg_type c;
      case ($urandom_range(0, 5))
         0, 1, 2: begin
            c.fx = {16'($urandom_range(200, 1500)), 16'($urandom)};
            c.fy = {16'($urandom_range(200, 1500)), 16'($urandom)};
            c.sk = spread(65536);
            c.u0 = {16'($urandom_range(0, 1920)), 16'($urandom)};
            c.v0 = {16'($urandom_range(0, 1080)), 16'($urandom)};
            c.k1 = spread(1 << 23);
            c.k2 = spread(1 << 21);
            c.k3 = spread(1 << 19);
            c.p1 = spread(1 << 17);
            c.p2 = spread(1 << 17);
         end
         3: begin
            c = {$urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom};
         end
         default: begin
            c = {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                 pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                 pick_extreme(), pick_extreme()};
         end
      endcase
      return c;
   endfunction

   function automatic logic [63:0] csr_word(cfg_type c, csr_idx_type idx);
      case (idx)
         CSR_FOCAL_X:         return {$urandom, c.fx};
         CSR_FOCAL_Y:         return {$urandom, c.fy};
         CSR_SKEW:            return {$urandom, c.sk};
         CSR_PRINCIPAL_POINT: return {c.u0, c.v0};
         CSR_RADIAL_K1:       return {$urandom, c.k1};
         CSR_RADIAL_K2:       return {$urandom, c.k2};
         CSR_RADIAL_K3:       return {$urandom, c.k3};
         CSR_TANGENTIAL:      return {c.p1, c.p2};
         default:             return '0;
      endcase
   endfunction

   task automatic csr_send(logic [CsrIdxWidth-1:0] idx, logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_setting(cfg_type c);
      for (int i = CSR_FOCAL_X; i <= CSR_TANGENTIAL; i++)
         csr_send(CsrIdxWidth'(i), csr_word(c, csr_idx_type'(i)));
      // unused slots must not disturb the setting
      if ($urandom_range(0, 1))
         csr_send(CsrIdxWidth'($urandom_range(CSR_TANGENTIAL + 1, CsrSlots - 1)),
                  {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, logic known,
                             pixel_type gold);
      start      <= 1'b1;
      req_norm_x <= x;
      req_norm_y <= y;
      gold_armed <= known;
      gold_pixel <= gold;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic pause_start(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_pixels();
      start <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic walk_probes(logic use_gold);
      foreach (probe_table[i])
         send_point(probe_table[i].x, probe_table[i].y, use_gold && probe_table[i].known,
                    probe_table[i].gold);
   endtask

   initial begin
      cfg_type wide_open;
      int      gap_pct;

      probe_table = '{
         '{32'sd0,            32'sd0,            1'b1, '{32'sd0,       32'sd0,       1'b0}},
         '{32'sh1000_0000,    32'sd0,            1'b1, '{32'sd65536,   32'sd0,       1'b0}},
         '{32'sd0,            32'sh1000_0000,    1'b1, '{32'sd0,       32'sd65536,   1'b0}},
         '{-32'sh1000_0000,   -32'sh1000_0000,   1'b1, '{-32'sd65536,  -32'sd65536,  1'b0}},
         // rounding ties go up
         '{32'sd2048,         -32'sd2048,        1'b1, '{32'sd1,       32'sd0,       1'b0}},
         '{-32'sd4096,        32'sd4096,         1'b1, '{-32'sd1,      32'sd1,       1'b0}},
         // r squared and tangential sums saturate
         '{32'sh8000_0000,    32'sh8000_0000,    1'b1, '{-32'sd524288, -32'sd524288, 1'b1}},
         '{32'sh7FFF_FFFF,    32'sh7FFF_FFFF,    1'b1, '{32'sd524288,  32'sd524288,  1'b1}},
         '{32'sh8000_0000,    32'sd0,            1'b1, '{-32'sd524288, 32'sd0,       1'b1}},
         '{32'sd0,            32'sh7FFF_FFFF,    1'b1, '{32'sd0,       32'sd524288,  1'b1}},
         '{32'sd1,            -32'sd1,           1'b0, '0},
         '{32'sh5A5A_5A5A,    32'shA5A5_A5A5,    1'b0, '0}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      walk_probes(1'b1);

      drain_pixels();
      wide_open = {WordMax | WordMin, WordMax | WordMin, WordMin, WordMax, WordMin,
                   WordMax, WordMin, WordMax, WordMin, WordMax};
      program_setting(wide_open);
      walk_probes(1'b0);

      for (int phase = 0; phase < RandomPhases; phase++) begin
         drain_pixels();
         program_setting(rand_setting());
         gap_pct = 0;
         for (int n = 0; n < PointsPerPhase; n++) begin
            if (n % 50 == 0) begin
               case ($urandom_range(0, 2))
                  0:       gap_pct = 0;
                  1:       gap_pct = 15;
                  default: gap_pct = 50;
               endcase
               if (phase == RandomPhases - 1)
                  gap_pct = 0;
            end
            if ($urandom_range(1, 100) <= gap_pct)
               pause_start($urandom_range(1, 12));
            send_point(rand_coord(), rand_coord(), 1'b0, '0);
         end
      end

      drain_pixels();
      repeat (SettleCycles) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* files.f */
rtl/ldp_pkg.sv
rtl/ldp_csr.sv
rtl/ldp_radial.sv
rtl/ldp_proj.sv
rtl/lens_distortion_project_unit.sv
test/testbench.sv
